// ===== rtl/core/lcpt_pkg.sv =====
package lcpt_pkg;

    localparam int ID_BITS    = 16;
    localparam int ID_COUNT   = 2 ** ID_BITS;
    localparam int CNT_BITS   = ID_BITS + 1;
    localparam int CODE_BITS  = 32;
    localparam int IO_CODE_W  = 32;
    localparam int OP_BITS    = 3;

    localparam logic [OP_BITS-1:0] OP_SET   = 3'd0;
    localparam logic [OP_BITS-1:0] OP_CLEAR = 3'd1;
    localparam logic [OP_BITS-1:0] OP_CLOSE = 3'd2;
    localparam logic [OP_BITS-1:0] OP_COUNT = 3'd3;
    localparam logic [OP_BITS-1:0] OP_QUERY = 3'd4;

    typedef enum logic [4:0] {
        ST_SWEEP = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_SLOT  = 5'b00100,
        ST_OWNER = 5'b01000,
        ST_HOLD  = 5'b10000
    } t_state;

endpackage

// ===== rtl/core/lazy_cleared_keyed_presence_table_unit.sv =====
// keyed presence table with constant-time close (sparse-set scheme)
// input channel: i_in_valid / o_in_stall carry an operation, an id and a code;
// an item is taken at a rising edge with i_in_valid high and o_in_stall low
// output channel: o_out_valid / i_out_stall carry found, stored code and the
// number of present ids after the item; one result item per input item
// order: the slot is read on the taking edge, then the owner, then compare and
// write-back registers the result; one item is in flight at a time, so the
// next item is not taken until the last one reaches write-back, because of
// the two dependent reads of the slot and owner memories
// the output register lets the next item be taken while a result still waits;
// if the receiver stalls and the finished register is still full, the next
// result holds in the write-back step and o_in_stall stays high
// reset: fill level and present count clear at once; then a sweep writes
// slot zero into every id-to-slot entry, during which o_in_stall is high;
// the slot owner and code memories are never cleared, as every read of
// them is checked against the fill level
module lazy_cleared_keyed_presence_table_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [lcpt_pkg::OP_BITS-1:0]         i_operation,
    input  logic [lcpt_pkg::ID_BITS-1:0]         i_entry_id,
    input  logic signed [lcpt_pkg::IO_CODE_W-1:0] i_entry_code,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic                                 o_found,
    output logic signed [lcpt_pkg::IO_CODE_W-1:0] o_stored_code,
    output logic [lcpt_pkg::CNT_BITS-1:0]        o_present_count
);
    import lcpt_pkg::*;

    logic [ID_BITS-1:0]   m_id_to_slot [ID_COUNT];
    logic [ID_BITS:0]     m_slot_owner [ID_COUNT];
    logic [CODE_BITS-1:0] m_code_store [ID_COUNT];

    t_state               r_state, n_state;
    logic [ID_BITS-1:0]   r_sweep_addr;
    logic [OP_BITS-1:0]   r_op;
    logic [ID_BITS-1:0]   r_id;
    logic [CODE_BITS-1:0] r_code;
    logic [ID_BITS-1:0]   r_slot_rd;
    logic [ID_BITS:0]     r_owner_rd;
    logic [CODE_BITS-1:0] r_code_rd;
    logic [CNT_BITS-1:0]  r_slots_used, n_slots_used;
    logic [CNT_BITS-1:0]  r_total, n_total;
    logic                 r_out_valid;
    logic                 r_found, n_found;
    logic [IO_CODE_W-1:0] r_out_code, n_out_code;

    logic                 in_take;
    logic                 out_free;
    logic                 finish;
    logic                 slot_ok;
    logic                 present;
    logic                 erased;
    logic                 can_alloc;

    logic                 slot_we;
    logic [ID_BITS-1:0]   slot_waddr;
    logic [ID_BITS-1:0]   slot_wdata;
    logic                 owner_we;
    logic [ID_BITS-1:0]   owner_waddr;
    logic [ID_BITS:0]     owner_wdata;
    logic                 code_we;
    logic [63:0]          code_ext;

    assign in_take  = (r_state == ST_IDLE) && i_in_valid;
    assign out_free = !r_out_valid || !i_out_stall;
    assign finish   = ((r_state == ST_OWNER) || (r_state == ST_HOLD)) && out_free;

    assign slot_ok   = {1'b0, r_slot_rd} < r_slots_used;
    assign present   = slot_ok && (r_owner_rd == {1'b0, r_id});
    assign erased    = slot_ok && (r_owner_rd == {1'b1, r_id});
    assign can_alloc = r_slots_used < CNT_BITS'(ID_COUNT);
    assign code_ext  = 64'($signed(r_code_rd));

    always_comb begin
        n_slots_used = r_slots_used;
        n_total      = r_total;
        n_found      = 1'b0;
        n_out_code   = '0;
        slot_we      = 1'b0;
        slot_waddr   = r_id;
        slot_wdata   = r_slots_used[ID_BITS-1:0];
        owner_we     = 1'b0;
        owner_waddr  = r_slot_rd;
        owner_wdata  = {1'b0, r_id};
        code_we      = 1'b0;
        if (r_state == ST_SWEEP) begin
            slot_we    = 1'b1;
            slot_waddr = r_sweep_addr;
            slot_wdata = '0;
        end else if (finish) begin
            case (r_op)
                OP_SET: begin
                    code_we = 1'b1;
                    if (!present) begin
                        if (erased) begin
                            owner_we = 1'b1;
                            n_total  = r_total + 1'b1;
                        end else if (can_alloc) begin
                            slot_we      = 1'b1;
                            owner_we     = 1'b1;
                            owner_waddr  = r_slots_used[ID_BITS-1:0];
                            n_slots_used = r_slots_used + 1'b1;
                            n_total      = r_total + 1'b1;
                        end
                    end
                end
                OP_CLEAR: begin
                    if (present) begin
                        owner_we    = 1'b1;
                        owner_wdata = {1'b1, r_id};
                        n_total     = r_total - 1'b1;
                    end
                end
                OP_CLOSE: begin
                    n_slots_used = '0;
                    n_total      = '0;
                end
                OP_QUERY: begin
                    n_found    = present;
                    n_out_code = present ? code_ext[IO_CODE_W-1:0] : '1;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_SWEEP: begin
                if (r_sweep_addr == '1) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_SLOT;
            end
            ST_SLOT:  n_state = ST_OWNER;
            ST_OWNER: n_state = out_free ? ST_IDLE : ST_HOLD;
            ST_HOLD: begin
                if (out_free) n_state = ST_IDLE;
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_SWEEP;
            r_sweep_addr <= '0;
            r_slots_used <= '0;
            r_total      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_slots_used <= n_slots_used;
            r_total      <= n_total;
            if (r_state == ST_SWEEP) r_sweep_addr <= r_sweep_addr + 1'b1;
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_op   <= i_operation;
            r_id   <= i_entry_id;
            r_code <= CODE_BITS'(64'(i_entry_code));
        end
        if (finish) begin
            r_found    <= n_found;
            r_out_code <= n_out_code;
        end
    end

    // memories: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (slot_we) m_id_to_slot[slot_waddr] <= slot_wdata;
        if (in_take) r_slot_rd <= m_id_to_slot[i_entry_id];
    end

    always_ff @(posedge i_clk) begin
        if (owner_we) m_slot_owner[owner_waddr] <= owner_wdata;
        if (r_state == ST_SLOT) r_owner_rd <= m_slot_owner[r_slot_rd];
    end

    always_ff @(posedge i_clk) begin
        if (code_we) m_code_store[r_id] <= r_code;
        if (in_take) r_code_rd <= m_code_store[i_entry_id];
    end

    assign o_in_stall      = (r_state != ST_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_found         = r_found;
    assign o_stored_code   = r_out_code;
    assign o_present_count = r_total;

endmodule

// ===== verif/lazy_cleared_keyed_presence_table_unit_test.sv =====
`timescale 1ns / 100ps

module lazy_cleared_keyed_presence_table_unit_test;
    import lcpt_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AFTER  = 400;
    localparam int RANDOM_ITEMS = 950;
    localparam logic [ID_BITS-1:0] ID_TOP = '1;

    typedef struct packed {
        logic                 found;
        logic [IO_CODE_W-1:0] code;
        logic [CNT_BITS-1:0]  count;
    } t_answer;

    class presence_tracker;
        bit [ID_BITS-1:0]   slot_of_id [ID_COUNT];
        bit [ID_BITS:0]     owner_of_slot [ID_COUNT];
        bit [CODE_BITS-1:0] code_of_id [ID_COUNT];
        int unsigned        fill_level;
        int unsigned        live_ids;
        t_answer            answers_due[$];
        int                 mismatches;
        int                 taken;

        // tombstone flag sits above the id
        function bit holds(logic [ID_BITS-1:0] id, bit tomb);
            bit [ID_BITS-1:0] s;
            s = slot_of_id[id];
            return s < fill_level && owner_of_slot[s] == {tomb, id};
        endfunction

        function void note_item(logic [OP_BITS-1:0] op, logic [ID_BITS-1:0] id,
                                logic [IO_CODE_W-1:0] code);
            t_answer a;
            a = '0;
            taken++;
            case (op)
                OP_SET: begin
                    code_of_id[id] = code;
                    if (!holds(id, 1'b0)) begin
                        if (holds(id, 1'b1) || fill_level < ID_COUNT) begin
                            if (!holds(id, 1'b1)) begin
                                slot_of_id[id] = fill_level[ID_BITS-1:0];
                                fill_level++;
                            end
                            live_ids++;
                            owner_of_slot[slot_of_id[id]] = {1'b0, id};
                        end
                    end
                end
                OP_CLEAR: begin
                    if (holds(id, 1'b0)) begin
                        owner_of_slot[slot_of_id[id]] = {1'b1, id};
                        live_ids--;
                    end
                end
                OP_CLOSE: begin
                    fill_level = 0;
                    live_ids   = 0;
                end
                OP_QUERY: begin
                    if (holds(id, 1'b0)) begin
                        a.found = 1'b1;
                        a.code  = code_of_id[id];
                    end else begin
                        a.code = '1;
                    end
                end
                default: ;
            endcase
            a.count = live_ids[CNT_BITS-1:0];
            answers_due.push_back(a);
        endfunction

        function void check_result(logic found, logic [IO_CODE_W-1:0] code,
                                   logic [CNT_BITS-1:0] count);
            t_answer want;
            if (answers_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: found=%0b code=%h count=%0d",
                             found, code, count);
                return;
            end
            want = answers_due.pop_front();
            if (found !== want.found || code !== want.code || count !== want.count) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: expected found=%0b code=%h count=%0d,",
                              " got found=%0b code=%h count=%0d"},
                             want.found, want.code, want.count, found, code, count);
            end
        endfunction
    endclass

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_stall;
    logic [OP_BITS-1:0]          i_operation = '0;
    logic [ID_BITS-1:0]          i_entry_id = '0;
    logic signed [IO_CODE_W-1:0] i_entry_code = '0;
    logic                        o_out_valid;
    logic                        i_out_stall = 1'b0;
    logic                        o_found;
    logic signed [IO_CODE_W-1:0] o_stored_code;
    logic [CNT_BITS-1:0]         o_present_count;

    presence_tracker tracker = new;
    int cycle_count = 0;
    int burst_left = 0;

    lazy_cleared_keyed_presence_table_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_operation     (i_operation),
        .i_entry_id      (i_entry_id),
        .i_entry_code    (i_entry_code),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_found         (o_found),
        .o_stored_code   (o_stored_code),
        .o_present_count (o_present_count)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver: own stall pattern plus one long hold-off
    initial begin
        int stall_mode;
        int rx_cycle;
        int hold_left;
        bit hold_done;
        stall_mode = 0;
        rx_cycle = 0;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall)
                tracker.check_result(o_found, o_stored_code, o_present_count);
            rx_cycle++;
            if (rx_cycle % 64 == 0)
                stall_mode = $urandom_range(0, 3);
            if (!hold_done && tracker.taken >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                case (stall_mode)
                    0: i_out_stall <= 1'b0;
                    1: i_out_stall <= ($urandom_range(0, 3) == 0);
                    2: i_out_stall <= (rx_cycle[2:1] == 2'b11);
                    default: i_out_stall <= ($urandom_range(0, 9) < 7);
                endcase
            end
        end
    end

    task automatic send_item(input logic [OP_BITS-1:0] op, input logic [ID_BITS-1:0] id,
                             input logic [IO_CODE_W-1:0] code);
        int gap;
        i_operation  <= op;
        i_entry_id   <= id;
        i_entry_code <= code;
        i_in_valid   <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        tracker.note_item(op, id, code);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 40);
            gap = $urandom_range(1, 12);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    initial begin
        logic [ID_BITS-1:0] pool [12];
        logic [ID_BITS-1:0] id;
        logic [IO_CODE_W-1:0] code;
        logic [OP_BITS-1:0] op;
        int phase_left;
        int pick;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part
        send_item(OP_COUNT, '0, '0);
        send_item(OP_QUERY, '0, '0);
        send_item(OP_SET, '0, 32'h8000_0000);
        send_item(OP_SET, ID_TOP, 32'h7fff_ffff);
        send_item(OP_QUERY, '0, '1);
        send_item(OP_QUERY, ID_TOP, '1);
        send_item(OP_SET, 16'h5a5a, '1);
        send_item(OP_QUERY, 16'h5a5a, '0);
        // replace the code of a present id
        send_item(OP_SET, '0, '0);
        send_item(OP_QUERY, '0, '0);
        send_item(OP_CLEAR, '0, '0);
        send_item(OP_QUERY, '0, '0);
        send_item(OP_CLEAR, '0, '0);
        send_item(OP_COUNT, '0, '0);
        // takes back its tombstoned slot
        send_item(OP_SET, '0, 32'h1234_5678);
        send_item(OP_QUERY, '0, '0);
        for (int k = int'(OP_QUERY) + 1; k < 2 ** OP_BITS; k++)
            send_item(OP_BITS'(k), 16'ha5a5, '1);
        send_item(OP_CLOSE, ID_TOP, '1);
        send_item(OP_QUERY, ID_TOP, '0);
        // stale slot numbers after close
        send_item(OP_SET, 16'ha5a5, 32'h0f0f_0f0f);
        send_item(OP_QUERY, '0, '0);
        send_item(OP_SET, ID_TOP, 32'hf0f0_f0f0);
        send_item(OP_QUERY, ID_TOP, '0);

        // random part: phases over a small pool of ids
        phase_left = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (phase_left == 0) begin
                phase_left = $urandom_range(40, 120);
                for (int k = 0; k < 12; k++)
                    pool[k] = ID_BITS'($urandom_range(0, 65535));
            end
            phase_left--;
            pick = $urandom_range(0, 99);
            if (pick < 38)      op = OP_SET;
            else if (pick < 58) op = OP_CLEAR;
            else if (pick < 85) op = OP_QUERY;
            else if (pick < 91) op = OP_COUNT;
            else if (pick < 97) op = OP_BITS'($urandom_range(int'(OP_QUERY) + 1,
                                                             2 ** OP_BITS - 1));
            else                op = OP_CLOSE;
            if ($urandom_range(0, 9) == 0)
                id = ID_BITS'($urandom_range(0, 65535));
            else
                id = pool[$urandom_range(0, 11)];
            case ($urandom_range(0, 9))
                0: code = 32'h8000_0000;
                1: code = 32'h7fff_ffff;
                2: code = '1;
                3: code = '0;
                default: code = $urandom();
            endcase
            send_item(op, id, code);
        end
        i_in_valid <= 1'b0;

        while (tracker.answers_due.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.answers_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
